// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, ignored while reset is high.
`define RAP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked property that also holds during reset.
`define RAP_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- rtl/core/rap_pkg.sv -----
`timescale 1ns / 1ps

package rap_pkg;

   localparam int NUMBER_WIDTH_DEFAULT = 32;

   // Framing characters
   localparam logic [7:0] CHAR_STAR   = 8'h2A;
   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   typedef enum logic [3:0] {
      MODE_START = 4'b0001,
      MODE_WS    = 4'b0010,
      MODE_RESP  = 4'b0100,
      MODE_STOP  = 4'b1000
   } mode_type;

   typedef enum logic [9:0] {
      PH_CNT_FIRST = 10'b00_0000_0001,
      PH_CNT_MORE  = 10'b00_0000_0010,
      PH_CNT_LF    = 10'b00_0000_0100,
      PH_DOLLAR    = 10'b00_0000_1000,
      PH_LEN_FIRST = 10'b00_0001_0000,
      PH_LEN_MORE  = 10'b00_0010_0000,
      PH_LEN_LF    = 10'b00_0100_0000,
      PH_PAYLOAD   = 10'b00_1000_0000,
      PH_SKIP      = 10'b01_0000_0000,
      PH_DONE      = 10'b10_0000_0000
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_MALFORMED = 2'd1,
      ST_TRUNCATED = 2'd2
   } status_type;

   typedef struct packed {
      mode_type  mode;
      phase_type phase;
      logic      inside_token;
   } ctrl_type;

   typedef struct packed {
      logic [7:0] token_byte;
      logic       byte_valid;
      logic       token_end;
      logic       message_done;
      status_type status;
   } result_type;

   localparam ctrl_type CTRL_RESET = '{mode: MODE_START, phase: PH_CNT_FIRST,
                                       inside_token: 1'b0};

endpackage

// ----- rtl/core/rap_step.sv -----
`timescale 1ns / 1ps

// One byte of parsing: next state and the result beat for that byte.
module rap_step #(
   parameter int NUMBER_WIDTH = rap_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic [7:0]              data_byte,
   input  logic                    end_of_message,
   input  rap_pkg::ctrl_type       ctrl_cur,
   input  logic [NUMBER_WIDTH-1:0] elements_cur,
   input  logic [NUMBER_WIDTH-1:0] bytes_cur,
   input  logic [NUMBER_WIDTH-1:0] acc_cur,
   output rap_pkg::ctrl_type       ctrl_nxt,
   output logic [NUMBER_WIDTH-1:0] elements_nxt,
   output logic [NUMBER_WIDTH-1:0] bytes_nxt,
   output logic [NUMBER_WIDTH-1:0] acc_nxt,
   output rap_pkg::result_type     result,
   output logic                    has_result
);
   import rap_pkg::*;

   localparam int WIDE = NUMBER_WIDTH + 4;

   logic            is_digit;
   logic            is_space;
   logic [WIDE-1:0] acc_ext;
   logic [WIDE-1:0] acc_sum;
   logic            acc_ovf;
   logic            used;
   ctrl_type        ctrl_v;

   // Character classes and the decimal accumulate (acc * 10 + digit)
   assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign is_space = (data_byte == CHAR_SPACE) ||
                     ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
   assign acc_ext  = {4'b0000, acc_cur};
   assign acc_sum  = (acc_ext << 3) + (acc_ext << 1) +
                     {{NUMBER_WIDTH{1'b0}}, data_byte[3:0]};
   assign acc_ovf  = |acc_sum[WIDE-1:NUMBER_WIDTH];

   always_comb begin
      ctrl_v       = ctrl_cur;
      elements_nxt = elements_cur;
      bytes_nxt    = bytes_cur;
      acc_nxt      = acc_cur;
      result       = '0;
      used         = 1'b0;

      // First byte picks the framing
      if (ctrl_v.mode == MODE_START) begin
         if (data_byte == CHAR_STAR) begin
            ctrl_v.mode  = MODE_RESP;
            ctrl_v.phase = PH_CNT_FIRST;
            used         = 1'b1;
         end else begin
            ctrl_v.mode = MODE_WS;
         end
      end

      if (!used) begin
         if (ctrl_v.mode == MODE_WS) begin
            if (is_space) begin
               result.token_end    = ctrl_v.inside_token;
               ctrl_v.inside_token = 1'b0;
            end else begin
               result.token_byte   = data_byte;
               result.byte_valid   = 1'b1;
               ctrl_v.inside_token = 1'b1;
            end
         end else if (ctrl_v.mode == MODE_RESP) begin
            unique case (ctrl_v.phase)
               PH_CNT_FIRST, PH_LEN_FIRST: begin
                  if (!is_digit) begin
                     ctrl_v.mode = MODE_STOP;
                  end else begin
                     acc_nxt      = NUMBER_WIDTH'(data_byte[3:0]);
                     ctrl_v.phase = (ctrl_v.phase == PH_CNT_FIRST) ? PH_CNT_MORE
                                                                   : PH_LEN_MORE;
                  end
               end
               PH_CNT_MORE, PH_LEN_MORE: begin
                  if (data_byte == CHAR_CR) begin
                     ctrl_v.phase = (ctrl_v.phase == PH_CNT_MORE) ? PH_CNT_LF
                                                                  : PH_LEN_LF;
                  end else if (!is_digit || acc_ovf) begin
                     ctrl_v.mode = MODE_STOP;
                  end else begin
                     acc_nxt = acc_sum[NUMBER_WIDTH-1:0];
                  end
               end
               PH_CNT_LF: begin
                  if (data_byte != CHAR_LF) begin
                     ctrl_v.mode = MODE_STOP;
                  end else begin
                     elements_nxt = acc_cur;
                     ctrl_v.phase = (acc_cur != '0) ? PH_DOLLAR : PH_DONE;
                  end
               end
               PH_DOLLAR: begin
                  if (data_byte != CHAR_DOLLAR) begin
                     ctrl_v.mode = MODE_STOP;
                  end else begin
                     ctrl_v.phase = PH_LEN_FIRST;
                  end
               end
               PH_LEN_LF: begin
                  if (data_byte != CHAR_LF) begin
                     ctrl_v.mode = MODE_STOP;
                  end else if (acc_cur == '0) begin
                     // empty element: token ends with no byte
                     result.token_end = 1'b1;
                     bytes_nxt        = NUMBER_WIDTH'(2);
                     ctrl_v.phase     = PH_SKIP;
                  end else begin
                     bytes_nxt    = acc_cur;
                     ctrl_v.phase = PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  result.token_byte = data_byte;
                  result.byte_valid = 1'b1;
                  bytes_nxt         = bytes_cur - NUMBER_WIDTH'(1);
                  if (bytes_cur == NUMBER_WIDTH'(1)) begin
                     result.token_end = 1'b1;
                     bytes_nxt        = NUMBER_WIDTH'(2);
                     ctrl_v.phase     = PH_SKIP;
                  end
               end
               PH_SKIP: begin
                  // two trailing bytes, content ignored
                  bytes_nxt = bytes_cur - NUMBER_WIDTH'(1);
                  if (bytes_cur == NUMBER_WIDTH'(1)) begin
                     elements_nxt = elements_cur - NUMBER_WIDTH'(1);
                     ctrl_v.phase = (elements_cur != NUMBER_WIDTH'(1)) ? PH_DOLLAR
                                                                       : PH_DONE;
                  end
               end
               PH_DONE: begin
               end
               default: begin
                  ctrl_v.mode = MODE_STOP;
               end
            endcase
         end
      end

      // Message end: status, closing token, back to reset state
      ctrl_nxt = ctrl_v;
      if (end_of_message) begin
         result.message_done = 1'b1;
         if (ctrl_v.mode == MODE_WS) begin
            if (ctrl_v.inside_token) begin
               result.token_end = 1'b1;
            end
         end else if (ctrl_v.mode == MODE_RESP) begin
            if (ctrl_v.phase == PH_PAYLOAD) begin
               result.token_end = 1'b1;
            end
            result.status = (ctrl_v.phase == PH_DONE) ? ST_OK : ST_TRUNCATED;
         end else if (ctrl_v.mode == MODE_STOP) begin
            result.status = ST_MALFORMED;
         end
         ctrl_nxt     = CTRL_RESET;
         elements_nxt = '0;
         bytes_nxt    = '0;
         acc_nxt      = '0;
      end

      has_result = result.byte_valid || result.token_end || result.message_done;
   end

endmodule

// ----- rtl/core/resp_array_token_parser.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Beat
// req_     in   tdata[7:0] data_byte, tlast end_of_message
// rsp_     out  tdata[7:0] token_byte, tuser[0] byte_valid, tuser[1] token_end,
//               tuser[3:2] status, tlast message_done
//
// One byte per cycle sustained while rsp_ does not stall; a byte passes from its req_
// beat through the input register and the single parse stage into the result register.
// Bytes that make no result (framing, skipped, ignored) advance the state but make no beat.
// Reset clears the parse state and both valid flags.
// A stall on rsp_ holds the result register; the input register keeps taking
// beats until it too is full.
module resp_array_token_parser #(
   parameter int NUMBER_WIDTH = rap_pkg::NUMBER_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] token_byte
   output logic [3:0] rsp_tuser,   // [0] byte_valid, [1] token_end, [3:2] status
   output logic       rsp_tlast
);
   import rap_pkg::*;

   logic                    in_valid_ff, in_valid_in;
   logic [7:0]              in_data_ff;
   logic                    in_last_ff;
   ctrl_type                ctrl_ff, ctrl_in;
   logic [NUMBER_WIDTH-1:0] elements_ff, elements_in;
   logic [NUMBER_WIDTH-1:0] bytes_ff, bytes_in;
   logic [NUMBER_WIDTH-1:0] acc_ff, acc_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   result_type              rsp_ff, step_result;
   logic                    step_has_result;
   logic                    out_free;
   logic                    advance;

   // Handshake: the parse stage moves when its result slot is free or draining
   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign advance     = in_valid_ff && out_free;
   assign req_tready  = !in_valid_ff || out_free;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      if (advance) begin
         rsp_valid_in = step_has_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   rap_step #(
      .NUMBER_WIDTH(NUMBER_WIDTH)
   ) u_step (
      .data_byte      (in_data_ff),
      .end_of_message (in_last_ff),
      .ctrl_cur       (ctrl_ff),
      .elements_cur   (elements_ff),
      .bytes_cur      (bytes_ff),
      .acc_cur        (acc_ff),
      .ctrl_nxt       (ctrl_in),
      .elements_nxt   (elements_in),
      .bytes_nxt      (bytes_in),
      .acc_nxt        (acc_in),
      .result         (step_result),
      .has_result     (step_has_result)
   );

   // Control and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctrl_ff      <= CTRL_RESET;
         elements_ff  <= '0;
         bytes_ff     <= '0;
         acc_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            ctrl_ff     <= ctrl_in;
            elements_ff <= elements_in;
            bytes_ff    <= bytes_in;
            acc_ff      <= acc_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_data_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && step_has_result) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.token_byte;
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.token_end, rsp_ff.byte_valid};
   assign rsp_tlast  = rsp_ff.message_done;

endmodule

// ----- rtl/core/rap_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the parser's result stream.
module rap_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tready,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [3:0] rsp_tuser,
   input logic       rsp_tlast
);
   import rap_pkg::*;

   // Every beat carries a byte, a token end or a message end
   `RAP_ASSERT(a_beat_nonempty, clock, reset, rsp_tvalid |-> (rsp_tuser[0] || rsp_tuser[1] || rsp_tlast))

   // Status only on the message end
   `RAP_ASSERT(a_status_at_end, clock, reset, (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser[3:2] == ST_OK))

   // No token byte shown without byte_valid
   `RAP_ASSERT(a_byte_zero, clock, reset, (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 8'h00))

   // Stalled beat holds
   `RAP_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast)))

   // Out of reset with nothing pending
   `RAP_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_tvalid && req_tready))

endmodule

bind resp_array_token_parser rap_checker u_rap_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
